[src/julia_escape_time_colour_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Julia escape-time block
// Shorthand for clocked properties that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_COLOUR_ASSERT_SVH
`define JULIA_ESCAPE_TIME_COLOUR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JETC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JETC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/jetc_pkg.sv]
// ----------------------------------------------------------------------------
// jetc_pkg
// Widths, register codes, reset values and the colour function of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package jetc_pkg;

  localparam int MAX_ITER  = 200;
  localparam int FRAC_BITS = 28;

  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int ESC_W   = 31;
  localparam int PIX_W   = 12;
  localparam int CNT_W   = 8;
  localparam int COL_W   = 24;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int Z_W     = (65 - FRAC_BITS > 44) ? 65 - FRAC_BITS : 44;

  // Fraction bits of the colour arithmetic.
  localparam int CQ = 30;

  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_C_RE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_C_IM      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_RE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_IM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STEP_RE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STEP_IM   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE_SQ = 3'd6;

  localparam logic signed [COORD_W-1:0] RST_C_RE      = -32'sd212064829;
  localparam logic signed [COORD_W-1:0] RST_C_IM      = 32'sd40265318;
  localparam logic signed [COORD_W-1:0] RST_ORIGIN_RE = -32'sd402653184;
  localparam logic signed [COORD_W-1:0] RST_ORIGIN_IM = 32'sd301989888;
  localparam logic [STEP_W-1:0]         RST_STEP_RE   = 31'd268435;
  localparam logic [STEP_W-1:0]         RST_STEP_IM   = 31'd268435;
  localparam logic [ESC_W-1:0]          RST_ESCAPE_SQ = 31'd1073741824;

  // Operands of the three multipliers of the shared unit.
  typedef struct packed {
    logic [COORD_W-1:0] a0;
    logic [COORD_W-1:0] b0;
    logic [COORD_W-1:0] a1;
    logic [COORD_W-1:0] b1;
    logic [COORD_W-1:0] a2;
    logic [COORD_W-1:0] b2;
  } mul_ops_t;

  // Power as a chain of products, each truncated to CQ fraction bits.
  function automatic logic [63:0] qpow(input logic [63:0] y, input int k);
    logic [63:0] a;
    a = y;
    for (int i = 1; i < k; i++) begin
      a = (a * y) >> CQ;
    end
    return a;
  endfunction

  // Colour of an escaped pixel, evaluated at elaboration only.
  function automatic logic [COL_W-1:0] colour_fn(input int n);
    logic [63:0] d;
    logic [63:0] y;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] cc;
    logic [63:0] x;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] sector;
    logic [63:0] w;
    logic [63:0] cand;
    logic [63:0] ch0;
    logic [63:0] ch1;
    logic [63:0] ch2;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    y = 64'd0;
    p = 64'd0;
    if (n > 0) begin
      d = (64'(n) << CQ) / MAX_ITER;
      for (int bit_i = CQ - 1; bit_i >= 0; bit_i--) begin
        cand = y | (64'd1 << bit_i);
        if (qpow(cand, 10) <= d) begin
          y = cand;
        end
      end
      p = qpow(y, 9);
    end
    s      = (64'd1 << CQ) - (p * 64'd3) / 5;
    cc     = (s * 64'd9) / 10;
    v      = ((64'd1 << CQ) * 64'd9) / 10;
    r      = (64'(MAX_ITER) + 64'd20 * 64'(n)) % (2 * MAX_ITER);
    q      = 64'd3 * r;
    sector = q / MAX_ITER;
    w      = q % MAX_ITER;
    if (sector[0]) begin
      x = (cc * (64'(MAX_ITER) - w)) / MAX_ITER;
    end else begin
      x = (cc * w) / MAX_ITER;
    end
    case (sector)
      64'd0: begin ch0 = cc;    ch1 = x;     ch2 = 64'd0; end
      64'd1: begin ch0 = x;     ch1 = cc;    ch2 = 64'd0; end
      64'd2: begin ch0 = 64'd0; ch1 = cc;    ch2 = x;     end
      64'd3: begin ch0 = 64'd0; ch1 = x;     ch2 = cc;    end
      64'd4: begin ch0 = x;     ch1 = 64'd0; ch2 = cc;    end
      default: begin ch0 = cc;  ch1 = 64'd0; ch2 = x;     end
    endcase
    b0 = 8'(((ch0 + v - cc) * 64'd255) >> CQ);
    b1 = 8'(((ch1 + v - cc) * 64'd255) >> CQ);
    b2 = 8'(((ch2 + v - cc) * 64'd255) >> CQ);
    return {b0, b1, b2};
  endfunction

endpackage

`default_nettype wire

[src/jetc_mul3.sv]
// ----------------------------------------------------------------------------
// jetc_mul3
// Three signed 32 x 32 multipliers with registered products.
// ----------------------------------------------------------------------------
`default_nettype none

module jetc_mul3 (
  input  logic                                clk,
  input  jetc_pkg::mul_ops_t                  ops,
  output logic signed [jetc_pkg::PROD_W-1:0] prod0,
  output logic signed [jetc_pkg::PROD_W-1:0] prod1,
  output logic signed [jetc_pkg::PROD_W-1:0] prod2
);
  import jetc_pkg::*;

  logic signed [PROD_W-1:0] prod0_r;
  logic signed [PROD_W-1:0] prod1_r;
  logic signed [PROD_W-1:0] prod2_r;

  always_ff @(posedge clk) begin
    prod0_r <= $signed(ops.a0) * $signed(ops.b0);
    prod1_r <= $signed(ops.a1) * $signed(ops.b1);
    prod2_r <= $signed(ops.a2) * $signed(ops.b2);
  end

  assign prod0 = prod0_r;
  assign prod1 = prod1_r;
  assign prod2 = prod2_r;

endmodule

`default_nettype wire

[src/jetc_colour_lut.sv]
// ----------------------------------------------------------------------------
// jetc_colour_lut
// Constant colour table indexed by the iteration count.
// ----------------------------------------------------------------------------
`default_nettype none

module jetc_colour_lut (
  input  logic [jetc_pkg::CNT_W-1:0] count,
  output logic [jetc_pkg::COL_W-1:0] colour
);
  import jetc_pkg::*;

  logic [COL_W-1:0] lut [2**CNT_W];

  // Entries at or above the iteration limit are never read for an escape.
  for (genvar i = 0; i < 2**CNT_W; i++) begin : g_lut
    if (i < MAX_ITER) begin : g_used
      localparam logic [COL_W-1:0] ENTRY = colour_fn(i);
      assign lut[i] = ENTRY;
    end else begin : g_spare
      assign lut[i] = '0;
    end
  end

  assign colour = lut[count];

endmodule

`default_nettype wire

[src/julia_escape_time_colour.sv]
// ----------------------------------------------------------------------------
// julia_escape_time_colour
// Escape-time iteration of a Julia set for one pixel, with table colouring.
// ----------------------------------------------------------------------------
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+--------------------------
//   input    | in_pixel_row, in_pixel_col             | start high, busy low
//   result   | out_escaped, out_iter_count, out_colour| out_valid, one cycle
//   config   | cfg_index, cfg_data                    | cfg_valid and cfg_ready
//
// An escaping item keeps the block busy for the START state and then a MUL
// and a STEP state per iteration and for the final test; an item that
// reaches the iteration limit stays busy for MAX_ITER iterations. In each
// iteration the MUL state registers the three products of the shared unit
// and the STEP state tests and updates. The result strobe comes in the
// first cycle with busy low, and a new item can be accepted in that same
// cycle. Reset is synchronous and active low; it returns the configuration
// registers to defaults. The receiver cannot stall: nothing waits on results.
// ----------------------------------------------------------------------------
`default_nettype none

module julia_escape_time_colour (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [jetc_pkg::PIX_W-1:0]           in_pixel_row,
  input  logic [jetc_pkg::PIX_W-1:0]           in_pixel_col,
  // Result channel
  output logic                                 out_valid,
  output logic                                 out_escaped,
  output logic [jetc_pkg::CNT_W-1:0]           out_iter_count,
  output logic [jetc_pkg::COL_W-1:0]           out_colour,
  // Configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [jetc_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [jetc_pkg::COORD_W-1:0]         cfg_data
);
  import jetc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_MUL,
    ST_STEP
  } state_t;

  // True when the value fits a 32-bit signed word with magnitude below 2^31.
  function automatic logic fits32(input logic signed [Z_W-1:0] v);
    logic [Z_W-32:0] hi;
    hi = v[Z_W-1:31];
    return (hi == '0) || ((hi == '1) && (v[30:0] != '0));
  endfunction

  // Configuration registers.
  logic signed [COORD_W-1:0] c_re_r, c_re_nxt;
  logic signed [COORD_W-1:0] c_im_r, c_im_nxt;
  logic signed [COORD_W-1:0] origin_re_r, origin_re_nxt;
  logic signed [COORD_W-1:0] origin_im_r, origin_im_nxt;
  logic [STEP_W-1:0]         step_re_r, step_re_nxt;
  logic [STEP_W-1:0]         step_im_r, step_im_nxt;
  logic [ESC_W-1:0]          escape_sq_r, escape_sq_nxt;

  // Sequencer and orbit state.
  state_t                    state_r, state_nxt;
  logic signed [Z_W-1:0]     z_re_r, z_re_nxt;
  logic signed [Z_W-1:0]     z_im_r, z_im_nxt;
  logic [CNT_W-1:0]          iter_r, iter_nxt;
  logic                      big_r, big_nxt;

  // Result registers.
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_escaped_r, out_escaped_nxt;
  logic [CNT_W-1:0]          out_iter_count_r, out_iter_count_nxt;
  logic [COL_W-1:0]          out_colour_r, out_colour_nxt;

  // Shared multiply unit.
  mul_ops_t                  ops;
  logic signed [PROD_W-1:0]  prod0;
  logic signed [PROD_W-1:0]  prod1;
  logic signed [PROD_W-1:0]  prod2;

  logic [COL_W-1:0]          lut_colour;

  // Datapath of the test-and-update step.
  logic [PROD_W-1:0]         mag_sum;
  logic [PROD_W-1:0]         limit;
  logic                      in_radius;
  logic signed [PROD_W-1:0]  diff;
  logic signed [PROD_W-1:0]  diff_sh;
  logic signed [PROD_W-1:0]  cross_sh;
  logic signed [Z_W-1:0]     new_re;
  logic signed [Z_W-1:0]     new_im;
  logic signed [Z_W-1:0]     start_re;
  logic signed [Z_W-1:0]     start_im;
  logic                      accept;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // While idle the first two multipliers form the pixel offsets, so the
  // products are ready in the cycle after an item is taken. Afterwards they
  // square the orbit point; the third multiplier always forms re * im.
  always_comb begin
    if (state_r == ST_IDLE) begin
      ops.a0 = {{(COORD_W-PIX_W){1'b0}}, in_pixel_col};
      ops.b0 = {{(COORD_W-STEP_W){1'b0}}, step_re_r};
      ops.a1 = {{(COORD_W-PIX_W){1'b0}}, in_pixel_row};
      ops.b1 = {{(COORD_W-STEP_W){1'b0}}, step_im_r};
    end else begin
      ops.a0 = z_re_r[COORD_W-1:0];
      ops.b0 = z_re_r[COORD_W-1:0];
      ops.a1 = z_im_r[COORD_W-1:0];
      ops.b1 = z_im_r[COORD_W-1:0];
    end
    ops.a2 = z_re_r[COORD_W-1:0];
    ops.b2 = z_im_r[COORD_W-1:0];
  end

  jetc_mul3 u_mul (
    .clk   (clk),
    .ops   (ops),
    .prod0 (prod0),
    .prod1 (prod1),
    .prod2 (prod2)
  );

  jetc_colour_lut u_lut (
    .count  (iter_r),
    .colour (lut_colour)
  );

  // Start point: the offsets are non-negative and fit well inside Z_W bits.
  assign start_re = {{(Z_W-COORD_W){origin_re_r[COORD_W-1]}}, origin_re_r}
                  + $signed(prod0[Z_W-1:0]);
  assign start_im = {{(Z_W-COORD_W){origin_im_r[COORD_W-1]}}, origin_im_r}
                  - $signed(prod1[Z_W-1:0]);

  // Escape test. When either coordinate is too large the products are
  // meaningless, but big_r already marks the point as outside.
  assign mag_sum   = $unsigned(prod0) + $unsigned(prod1);
  assign limit     = {{(PROD_W-ESC_W-FRAC_BITS){1'b0}}, escape_sq_r, {FRAC_BITS{1'b0}}};
  assign in_radius = !big_r && (mag_sum <= limit);

  // Next point. An arithmetic shift is a floor division by 2^FRAC_BITS, and
  // shifting the cross product one place less doubles it.
  assign diff     = prod0 - prod1;
  assign diff_sh  = diff >>> FRAC_BITS;
  assign cross_sh = prod2 >>> (FRAC_BITS - 1);
  assign new_re   = $signed(diff_sh[Z_W-1:0])
                  + {{(Z_W-COORD_W){c_re_r[COORD_W-1]}}, c_re_r};
  assign new_im   = $signed(cross_sh[Z_W-1:0])
                  + {{(Z_W-COORD_W){c_im_r[COORD_W-1]}}, c_im_r};

  always_comb begin
    c_re_nxt           = c_re_r;
    c_im_nxt           = c_im_r;
    origin_re_nxt      = origin_re_r;
    origin_im_nxt      = origin_im_r;
    step_re_nxt        = step_re_r;
    step_im_nxt        = step_im_r;
    escape_sq_nxt      = escape_sq_r;
    state_nxt          = state_r;
    z_re_nxt           = z_re_r;
    z_im_nxt           = z_im_r;
    iter_nxt           = iter_r;
    big_nxt            = big_r;
    out_valid_nxt      = 1'b0;
    out_escaped_nxt    = out_escaped_r;
    out_iter_count_nxt = out_iter_count_r;
    out_colour_nxt     = out_colour_r;

    // Configuration writes; an index beyond the register list is dropped.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_C_RE:      c_re_nxt      = cfg_data;
        REG_C_IM:      c_im_nxt      = cfg_data;
        REG_ORIGIN_RE: origin_re_nxt = cfg_data;
        REG_ORIGIN_IM: origin_im_nxt = cfg_data;
        REG_STEP_RE:   step_re_nxt   = cfg_data[STEP_W-1:0];
        REG_STEP_IM:   step_im_nxt   = cfg_data[STEP_W-1:0];
        REG_ESCAPE_SQ: escape_sq_nxt = cfg_data[ESC_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        z_re_nxt  = start_re;
        z_im_nxt  = start_im;
        iter_nxt  = '0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // The products of this point are registered at the end of this cycle.
        big_nxt   = !fits32(z_re_r) || !fits32(z_im_r);
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (!in_radius) begin
          // Left the radius before the limit, possibly before any iteration.
          out_valid_nxt      = 1'b1;
          out_escaped_nxt    = 1'b1;
          out_iter_count_nxt = iter_r;
          out_colour_nxt     = lut_colour;
          state_nxt          = ST_IDLE;
        end else begin
          z_re_nxt = new_re;
          z_im_nxt = new_im;
          iter_nxt = iter_r + 1'b1;
          if (iter_r == CNT_W'(MAX_ITER - 1)) begin
            // Limit reached: the last point is not tested.
            out_valid_nxt      = 1'b1;
            out_escaped_nxt    = 1'b0;
            out_iter_count_nxt = CNT_W'(MAX_ITER);
            out_colour_nxt     = '0;
            state_nxt          = ST_IDLE;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    z_re_r           <= z_re_nxt;
    z_im_r           <= z_im_nxt;
    iter_r           <= iter_nxt;
    big_r            <= big_nxt;
    out_escaped_r    <= out_escaped_nxt;
    out_iter_count_r <= out_iter_count_nxt;
    out_colour_r     <= out_colour_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      c_re_r      <= RST_C_RE;
      c_im_r      <= RST_C_IM;
      origin_re_r <= RST_ORIGIN_RE;
      origin_im_r <= RST_ORIGIN_IM;
      step_re_r   <= RST_STEP_RE;
      step_im_r   <= RST_STEP_IM;
      escape_sq_r <= RST_ESCAPE_SQ;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      c_re_r      <= c_re_nxt;
      c_im_r      <= c_im_nxt;
      origin_re_r <= origin_re_nxt;
      origin_im_r <= origin_im_nxt;
      step_re_r   <= step_re_nxt;
      step_im_r   <= step_im_nxt;
      escape_sq_r <= escape_sq_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_escaped    = out_escaped_r;
  assign out_iter_count = out_iter_count_r;
  assign out_colour     = out_colour_r;

endmodule

`default_nettype wire

[src/jetc_check.sv]
// ----------------------------------------------------------------------------
// jetc_check
// Port-level checks of the Julia escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "julia_escape_time_colour_assert.svh"

module jetc_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_escaped,
  input logic [jetc_pkg::CNT_W-1:0] out_iter_count,
  input logic [jetc_pkg::COL_W-1:0] out_colour
);
  import jetc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ITER);

  // A result is only given once the item is finished.
  `JETC_ASSERT_NOW(a_result_idle, out_valid, !busy, "result strobe while busy")

  // A taken item occupies the block and cannot finish in the next cycle.
  `JETC_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !out_valid, "item not taken up")

  // Pixels that stay bounded report the limit and no colour.
  `JETC_ASSERT_NOW(a_bounded, out_valid && !out_escaped, (out_iter_count == CNT_LIMIT) && (out_colour == '0), "bounded pixel result wrong")

  // Escaped pixels always stop short of the limit.
  `JETC_ASSERT_NOW(a_escaped, out_valid && out_escaped, out_iter_count < CNT_LIMIT, "escape count at limit")

endmodule

bind julia_escape_time_colour jetc_check u_jetc_check (.*);

`default_nettype wire

[bench/tb_julia_escape_time_colour.sv]
// ----------------------------------------------------------------------------
// tb_julia_escape_time_colour
// Self-checking bench for the Julia escape-time pixel block. Pixels go in
// through the start/busy handshake and a local predictor computes each
// expected result from its own copy of the registers. Every result strobe is
// compared field by field with the oldest expected result. Register sets are
// changed between phases, only while no pixel is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_julia_escape_time_colour;

  import jetc_pkg::*;

  // One expected or observed pixel result.
  typedef struct packed {
    logic             escaped;
    logic [CNT_W-1:0] count;
    logic [COL_W-1:0] colour;
  } pixel_result_t;

  // One entry of the driver's work list: a register write or a pixel item.
  typedef struct packed {
    logic                 is_write;
    logic [REG_IDX_W-1:0] idx;
    logic [COORD_W-1:0]   data;
    logic [PIX_W-1:0]     row;
    logic [PIX_W-1:0]     col;
  } drive_op_t;

  // Clock, reset and every input of the block start at known values.
  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic [PIX_W-1:0]     in_pixel_row = '0;
  logic [PIX_W-1:0]     in_pixel_col = '0;
  logic                 cfg_valid    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index    = '0;
  logic [COORD_W-1:0]   cfg_data     = '0;

  logic                 busy;
  logic                 out_valid;
  logic                 out_escaped;
  logic [CNT_W-1:0]     out_iter_count;
  logic [COL_W-1:0]     out_colour;
  logic                 cfg_ready;

  julia_escape_time_colour dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_pixel_row   (in_pixel_row),
    .in_pixel_col   (in_pixel_col),
    .out_valid      (out_valid),
    .out_escaped    (out_escaped),
    .out_iter_count (out_iter_count),
    .out_colour     (out_colour),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work still to be driven, and results the block still owes us.
  drive_op_t     pending_ops[$];
  pixel_result_t awaited_px[$];

  // Acceptance flags, set at the rising edge and read by the driver at the
  // following falling edge.
  bit px_taken = 1'b0;
  bit wr_taken = 1'b0;

  // Percentage of cycles in which the sender holds back a ready pixel.
  int unsigned sender_idle_pct = 33;
  int unsigned n_err = 0;

  // Local copy of the configuration registers, kept in step with the writes
  // the block accepts.
  logic signed [COORD_W-1:0] c_re_q;
  logic signed [COORD_W-1:0] c_im_q;
  logic signed [COORD_W-1:0] origin_re_q;
  logic signed [COORD_W-1:0] origin_im_q;
  logic [STEP_W-1:0]         step_re_q;
  logic [STEP_W-1:0]         step_im_q;
  logic [ESC_W-1:0]          escape_sq_q;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Fixed-point power in which every partial product is cut back to CQ
  // fraction bits, exactly as the color path of the block does it.
  function automatic logic [63:0] trunc_power(input logic [63:0] base, input int expo);
    logic [63:0] acc;
    acc = base;
    repeat (expo - 1) acc = (acc * base) >> CQ;
    return acc;
  endfunction

  // Color of a pixel that escaped after n iterations. The saturation comes
  // from the ninth power of the tenth root of n/MAX_ITER, the hue walks the
  // six HSV sectors, and the value is fixed at 0.9. All steps truncate.
  function automatic logic [COL_W-1:0] escape_colour(input int unsigned n);
    logic [63:0] one;
    logic [63:0] lim;
    logic [63:0] frac_n;
    logic [63:0] root;
    logic [63:0] trial;
    logic [63:0] sat_pow;
    logic [63:0] chroma;
    logic [63:0] val;
    logic [63:0] q3;
    logic [63:0] sector;
    logic [63:0] w;
    logic [63:0] side;
    logic [63:0] red;
    logic [63:0] grn;
    logic [63:0] blu;
    one     = 64'd1 << CQ;
    lim     = 64'(MAX_ITER);
    root    = 64'd0;
    sat_pow = 64'd0;
    if (n != 0) begin
      frac_n = (64'(n) << CQ) / lim;
      // Bitwise search for the largest root whose truncated tenth power
      // does not exceed n/MAX_ITER.
      for (int bitpos = CQ - 1; bitpos >= 0; bitpos--) begin
        trial = root | (64'd1 << bitpos);
        if (trunc_power(trial, 10) <= frac_n) begin
          root = trial;
        end
      end
      sat_pow = trunc_power(root, 9);
    end
    chroma = ((one - (sat_pow * 64'd3) / 64'd5) * 64'd9) / 64'd10;
    val    = (one * 64'd9) / 64'd10;
    q3     = 64'd3 * ((lim + 64'd20 * 64'(n)) % (64'd2 * lim));
    sector = q3 / lim;
    w      = q3 % lim;
    // The secondary component rises across even sectors and falls across
    // odd ones.
    if (sector[0]) begin
      side = (chroma * (lim - w)) / lim;
    end else begin
      side = (chroma * w) / lim;
    end
    case (sector)
      64'd0:   begin red = chroma; grn = side;   blu = 64'd0;  end
      64'd1:   begin red = side;   grn = chroma; blu = 64'd0;  end
      64'd2:   begin red = 64'd0;  grn = chroma; blu = side;   end
      64'd3:   begin red = 64'd0;  grn = side;   blu = chroma; end
      64'd4:   begin red = side;   grn = 64'd0;  blu = chroma; end
      default: begin red = chroma; grn = 64'd0;  blu = side;   end
    endcase
    red = ((red + val - chroma) * 64'd255) >> CQ;
    grn = ((grn + val - chroma) * 64'd255) >> CQ;
    blu = ((blu + val - chroma) * 64'd255) >> CQ;
    return {red[7:0], grn[7:0], blu[7:0]};
  endfunction

  // Escape test. A component of 2^31 or more in magnitude is outside by
  // definition; otherwise the exact squared modulus is compared with the
  // escape limit scaled up to the same number of fraction bits.
  function automatic bit orbit_bounded(input logic signed [63:0] re,
                                       input logic signed [63:0] im);
    logic [63:0] ar;
    logic [63:0] ai;
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    if (ar >= (64'd1 << 31) || ai >= (64'd1 << 31)) begin
      return 1'b0;
    end
    return (ar * ar + ai * ai) <= ({33'd0, escape_sq_q} << FRAC_BITS);
  endfunction

  // Runs the orbit of one pixel with the current registers.
  function automatic pixel_result_t predict_pixel(input logic [PIX_W-1:0] row,
                                                  input logic [PIX_W-1:0] col);
    logic signed [63:0] re;
    logic signed [63:0] im;
    logic signed [63:0] nre;
    logic signed [63:0] cr;
    logic signed [63:0] ci;
    logic signed [63:0] stp_re;
    logic signed [63:0] stp_im;
    int unsigned        n;
    pixel_result_t      res;
    cr     = c_re_q;
    ci     = c_im_q;
    stp_re = {33'd0, step_re_q};
    stp_im = {33'd0, step_im_q};
    re     = origin_re_q;
    im     = origin_im_q;
    re     = re + $signed({52'd0, col}) * stp_re;
    im     = im - $signed({52'd0, row}) * stp_im;
    n      = 0;
    // Arithmetic right shifts of signed values round toward minus infinity,
    // which is the rounding the block uses after each square.
    while (n < MAX_ITER && orbit_bounded(re, im)) begin
      nre = ((re * re - im * im) >>> FRAC_BITS) + cr;
      im  = (((re * im) <<< 1) >>> FRAC_BITS) + ci;
      re  = nre;
      n++;
    end
    res.escaped = (n < MAX_ITER);
    res.count   = n[CNT_W-1:0];
    res.colour  = res.escaped ? escape_colour(n) : '0;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Monitor: tracks register writes, predicts accepted pixels and checks
  // every result strobe against the oldest prediction.
  // ------------------------------------------------------------------------

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      n_err++;
    end
  endtask

  always @(posedge clk) begin : monitor_p
    pixel_result_t want;
    if (!rst_n) begin
      c_re_q      = RST_C_RE;
      c_im_q      = RST_C_IM;
      origin_re_q = RST_ORIGIN_RE;
      origin_im_q = RST_ORIGIN_IM;
      step_re_q   = RST_STEP_RE;
      step_im_q   = RST_STEP_IM;
      escape_sq_q = RST_ESCAPE_SQ;
      px_taken    <= 1'b0;
      wr_taken    <= 1'b0;
    end else begin
      px_taken <= start && !busy;
      wr_taken <= cfg_valid && cfg_ready;
      if (out_valid) begin
        if (awaited_px.size() == 0) begin
          $display("%0t: result with nothing expected: escaped %0b count %0d colour %06h",
                   $time, out_escaped, out_iter_count, out_colour);
          n_err++;
        end else begin
          want = awaited_px.pop_front();
          check_field("escaped", {31'd0, want.escaped}, {31'd0, out_escaped});
          check_field("iter_count", {24'd0, want.count}, {24'd0, out_iter_count});
          check_field("colour", {8'd0, want.colour}, {8'd0, out_colour});
        end
      end
      // Writes only happen while no pixel is in flight, so updating the
      // local registers with blocking assignments here cannot disturb a
      // prediction made in the same cycle.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_C_RE:      c_re_q      = cfg_data;
          REG_C_IM:      c_im_q      = cfg_data;
          REG_ORIGIN_RE: origin_re_q = cfg_data;
          REG_ORIGIN_IM: origin_im_q = cfg_data;
          REG_STEP_RE:   step_re_q   = cfg_data[STEP_W-1:0];
          REG_STEP_IM:   step_im_q   = cfg_data[STEP_W-1:0];
          REG_ESCAPE_SQ: escape_sq_q = cfg_data[ESC_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        awaited_px.push_back(predict_pixel(in_pixel_row, in_pixel_col));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Driver: works through the pending list at the falling edge. A pixel is
  // held on the ports until the block takes it. A register write waits until
  // the block is idle and every owed result has come back.
  // ------------------------------------------------------------------------

  always @(negedge clk) begin : driver_p
    drive_op_t op;
    bit        hold_px;
    bit        hold_wr;
    bit        next_start;
    bit        next_wr;
    if (rst_n) begin
      hold_px    = start && !px_taken;
      hold_wr    = cfg_valid && !wr_taken;
      next_start = hold_px;
      next_wr    = hold_wr;
      if (!hold_px && !hold_wr && pending_ops.size() > 0) begin
        if (pending_ops[0].is_write) begin
          if (awaited_px.size() == 0 && !busy) begin
            op        = pending_ops.pop_front();
            next_wr   = 1'b1;
            cfg_index <= op.idx;
            cfg_data  <= op.data;
          end
        end else if ($urandom_range(99) >= sender_idle_pct) begin
          op           = pending_ops.pop_front();
          next_start   = 1'b1;
          in_pixel_row <= op.row;
          in_pixel_col <= op.col;
        end
      end
      // A single assignment per edge keeps back-to-back items glitch free.
      start     <= next_start;
      cfg_valid <= next_wr;
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  task automatic push_pixel(input logic [PIX_W-1:0] row, input logic [PIX_W-1:0] col);
    drive_op_t op;
    op          = '0;
    op.is_write = 1'b0;
    op.row      = row;
    op.col      = col;
    pending_ops.push_back(op);
  endtask

  task automatic push_write(input logic [REG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    drive_op_t op;
    op          = '0;
    op.is_write = 1'b1;
    op.idx      = idx;
    op.data     = data;
    pending_ops.push_back(op);
  endtask

  // Queues a full register set, one write per register.
  task automatic push_reg_set(input logic [31:0] c_re, input logic [31:0] c_im,
                              input logic [31:0] o_re, input logic [31:0] o_im,
                              input logic [31:0] s_re, input logic [31:0] s_im,
                              input logic [31:0] esc);
    push_write(REG_C_RE, c_re);
    push_write(REG_C_IM, c_im);
    push_write(REG_ORIGIN_RE, o_re);
    push_write(REG_ORIGIN_IM, o_im);
    push_write(REG_STEP_RE, s_re);
    push_write(REG_STEP_IM, s_im);
    push_write(REG_ESCAPE_SQ, esc);
  endtask

  // Returns once everything queued has been driven and answered.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || awaited_px.size() != 0 || start || cfg_valid) begin
      @(posedge clk);
    end
  endtask

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------

  initial begin : stimulus_p
    logic [31:0] span;
    logic [31:0] c_re;
    logic [31:0] c_im;
    logic [31:0] o_re;
    logic [31:0] o_im;
    logic [31:0] esc;
    // Synchronous reset, released at a falling edge.
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. First the reset view: the corners, the pixel nearest
    // the origin, and alternating bit patterns on both coordinates.
    sender_idle_pct = 33;
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd4095, 12'd4095);
    push_pixel(12'd0, 12'd4095);
    push_pixel(12'd4095, 12'd0);
    push_pixel(12'd1125, 12'd1500);
    push_pixel(12'hAAA, 12'h555);
    push_pixel(12'h555, 12'hAAA);
    wait_drained();

    // The orbit of zero with c zero and a zero escape limit never leaves,
    // so the iteration limit is reached. One step to the right already lies
    // outside a zero radius and escapes before any iteration.
    push_reg_set(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_pixel(12'd7, 12'd9);
    wait_drained();
    push_write(REG_STEP_RE, 32'd1);
    push_pixel(12'd0, 12'd1);
    push_pixel(12'd0, 12'd0);
    wait_drained();

    // Extreme register values: start points far outside the radius, and an
    // orbit that leaves through the most negative c after one step.
    push_reg_set(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_pixel(12'd0, 12'd0);
    push_pixel(12'd4095, 12'd4095);
    push_pixel(12'd0, 12'd4095);
    wait_drained();
    push_reg_set(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    push_pixel(12'd100, 12'd200);
    wait_drained();

    // Reset view again, with the largest escape limit.
    push_reg_set(RST_C_RE, RST_C_IM, RST_ORIGIN_RE, RST_ORIGIN_IM,
                 {1'b0, RST_STEP_RE}, {1'b0, RST_STEP_IM}, 32'h7FFF_FFFF);
    push_pixel(12'd1125, 12'd1500);
    push_pixel(12'd1000, 12'd1200);
    push_pixel(12'd1300, 12'd1800);
    wait_drained();

    // Random part in twelve phases. Most phases frame the region around the
    // set with a random c of parts between -1 and 1, so that iteration counts
    // spread over the whole range; every fourth phase uses fully random
    // registers. The sender idles sometimes, then often, then never.
    for (int ph = 0; ph < 12; ph++) begin
      sender_idle_pct = (ph < 4) ? 33 : ((ph < 8) ? 85 : 0);
      if (ph % 4 == 3) begin
        push_reg_set($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        span = $urandom_range(290000, 180000);
        c_re = $urandom_range(32'h2000_0000) - 32'h1000_0000;
        c_im = $urandom_range(32'h2000_0000) - 32'h1000_0000;
        o_re = $urandom_range(32'h0400_0000) - 32'h0200_0000 - span * 32'd2048;
        o_im = $urandom_range(32'h0400_0000) - 32'h0200_0000 + span * 32'd2048;
        esc  = (ph % 3 == 1) ? $urandom_range(32'h7FFF_FFFF, 32'h1000_0000)
                             : 32'h4000_0000;
        push_reg_set(c_re, c_im, o_re, o_im, span, span + $urandom_range(4096), esc);
      end
      for (int k = 0; k < 162; k++) begin
        push_pixel($urandom_range(4095), $urandom_range(4095));
      end
      wait_drained();
    end

    // Give a stray late strobe time to show up before the verdict.
    repeat (2 * MAX_ITER + 8) @(posedge clk);
    if (n_err == 0 && awaited_px.size() == 0) begin
      $display("tb_julia_escape_time_colour: PASS");
    end else begin
      $display("tb_julia_escape_time_colour: FAIL");
    end
    $finish;
  end

  // Watchdog. The slowest legal run is about two thousand pixels at the
  // iteration limit, each busy for MAX_ITER iterations plus sender gaps, under 2 ms.
  initial begin : watchdog_p
    #8_000_000;
    $display("%0t: timeout with %0d results still owed", $time, awaited_px.size());
    $display("tb_julia_escape_time_colour: FAIL");
    $finish;
  end

endmodule
